// ===== hw/rtl/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types and character constants for the NMEA sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

    // Sentence delimiters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam int         WORD_BYTES   = 8;
    localparam int         WORD_LIMIT   = 128;  // 16 words of 8 bytes
    localparam logic [7:0] MAX_LEN_INIT = 8'd128;

    // Store address is wide enough for the largest usable store
    localparam int STORE_AW = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PACK,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } wr_t;

endpackage

// ===== hw/rtl/nsf_store.sv =====
// ----------------------------------------------------------------------------
// nsf_store
// Sentence byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nsf_store #(
    parameter int DEPTH = 128
) (
    input  logic                         clk,
    input  nsf_pkg::wr_t                 wr,
    input  logic [nsf_pkg::STORE_AW-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/nmea_sentence_framer.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Cuts NMEA 0183 sentences out of a byte stream and emits them as 8-byte words.
// ----------------------------------------------------------------------------
// While a sentence is being collected the block accepts one byte per
// cycle. When CR LF closes a sentence the block raises in_stall and
// reads the sentence back out of its byte store: each stored byte is
// addressed (ST_FETCH), then packed into the word (ST_PACK), and each
// emitted word is held in ST_SEND as long as out_stall is high. The
// sentence length limit is the smallest of the configured maximum length
// (cfg_data), BUFFER_DEPTH and 128; longer sentences are dropped silently.
module nmea_sentence_framer #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] frame_word,
    output logic [3:0]  byte_count,
    output logic        last_of_frame
);

    localparam int STORE_DEPTH = (BUFFER_DEPTH < nsf_pkg::WORD_LIMIT) ?
                                 BUFFER_DEPTH : nsf_pkg::WORD_LIMIT;
    localparam logic [7:0] STORE_DEPTH_B = 8'(STORE_DEPTH);

    nsf_pkg::state_t state_reg, state_next;
    logic [7:0]  max_len_reg, max_len_next;
    logic [7:0]  fill_reg, fill_next;
    logic        in_frame_reg, in_frame_next;
    logic        cr_seen_reg, cr_seen_next;
    logic [7:0]  rd_ptr_reg, rd_ptr_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [63:0] word_reg, word_next;

    nsf_pkg::wr_t wr;
    logic [7:0]  rd_data;
    logic [7:0]  limit;
    logic        in_fire;
    logic        is_start;

    nsf_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_ptr_reg[nsf_pkg::STORE_AW-1:0]),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign limit     = (max_len_reg > STORE_DEPTH_B) ? STORE_DEPTH_B : max_len_reg;
    assign in_stall  = (state_reg != nsf_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign is_start  = (data_byte == nsf_pkg::CHAR_DOLLAR) ||
                       (data_byte == nsf_pkg::CHAR_BANG);

    assign out_valid     = (state_reg == nsf_pkg::ST_SEND);
    assign frame_word    = word_reg;
    assign byte_count    = cnt_reg;
    assign last_of_frame = last_reg;

    always_comb
    begin
        state_next    = state_reg;
        max_len_next  = max_len_reg;
        fill_next     = fill_reg;
        in_frame_next = in_frame_reg;
        cr_seen_next  = cr_seen_reg;
        rd_ptr_next   = rd_ptr_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        word_next     = word_reg;
        wr.en         = 1'b0;
        wr.addr       = fill_reg[nsf_pkg::STORE_AW-1:0];
        wr.data       = data_byte;

        if (cfg_valid && cfg_ready)
        begin
            max_len_next = cfg_data;
        end

        unique case (state_reg)
            nsf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (is_start)
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = '0;
                        fill_next     = 8'd1;
                        in_frame_next = 1'b1;
                        cr_seen_next  = 1'b0;
                    end
                    else if (!in_frame_reg)
                    begin
                        // hunting: byte outside a sentence
                    end
                    else if (fill_reg >= limit)
                    begin
                        fill_next     = '0;
                        in_frame_next = 1'b0;
                        cr_seen_next  = 1'b0;
                    end
                    else
                    begin
                        wr.en     = 1'b1;
                        fill_next = fill_reg + 8'd1;
                        if (data_byte == nsf_pkg::CHAR_LF && cr_seen_reg)
                        begin
                            // sentence complete, drain it
                            in_frame_next = 1'b0;
                            cr_seen_next  = 1'b0;
                            rd_ptr_next   = '0;
                            cnt_next      = '0;
                            last_next     = 1'b0;
                            word_next     = '0;
                            state_next    = nsf_pkg::ST_FETCH;
                        end
                        else
                        begin
                            cr_seen_next = (data_byte == nsf_pkg::CHAR_CR);
                        end
                    end
                end
            end

            nsf_pkg::ST_FETCH:
            begin
                // store read of rd_ptr lands in rd_data at this edge
                state_next = nsf_pkg::ST_PACK;
            end

            nsf_pkg::ST_PACK:
            begin
                word_next   = word_reg | ({56'd0, rd_data} << {cnt_reg[2:0], 3'b000});
                cnt_next    = cnt_reg + 4'd1;
                rd_ptr_next = rd_ptr_reg + 8'd1;
                if (rd_ptr_next == fill_reg)
                begin
                    last_next  = 1'b1;
                    state_next = nsf_pkg::ST_SEND;
                end
                else if (cnt_next == 4'(nsf_pkg::WORD_BYTES))
                begin
                    state_next = nsf_pkg::ST_SEND;
                end
                else
                begin
                    state_next = nsf_pkg::ST_FETCH;
                end
            end

            nsf_pkg::ST_SEND:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        fill_next  = '0;
                        last_next  = 1'b0;
                        state_next = nsf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        word_next  = '0;
                        cnt_next   = '0;
                        state_next = nsf_pkg::ST_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = nsf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nsf_pkg::ST_IDLE;
            max_len_reg  <= nsf_pkg::MAX_LEN_INIT;
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            cr_seen_reg  <= 1'b0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            max_len_reg  <= max_len_next;
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            cr_seen_reg  <= cr_seen_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== hw/rtl/nsf_checker.sv =====
// ----------------------------------------------------------------------------
// nsf_checker
// Port-level checks for the NMEA sentence framer, bound to the top level.
// ----------------------------------------------------------------------------
module nsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] frame_word,
    input logic [3:0]  byte_count,
    input logic        last_of_frame
);

    // no input request is taken while a word is pending
    a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && !in_stall))
        else $error("input accepted while a word is pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
        else $error("byte_count out of range");

    // only the last word of a sentence may be short
    a_full_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_frame |-> byte_count == 4'd8)
        else $error("short word before end of sentence");

    // unused byte lanes read as zero
    a_upper_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_count < 4'd8) |->
            (frame_word >> {byte_count[2:0], 3'b000}) == 64'd0)
        else $error("nonzero data beyond byte_count");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_word) &&
            $stable(byte_count) && $stable(last_of_frame))
        else $error("stalled output changed");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_word    (frame_word),
    .byte_count    (byte_count),
    .last_of_frame (last_of_frame)
);
